// ===== hdl/hla_pkg.sv =====
// Shared types and constants for the hole list allocator.
// Holds list geometry, status and policy codes, entry and pick structs, FSM states.
// No dependencies.
package hla_pkg;

  localparam int LIST_DEPTH  = 64;
  localparam int ADDR_W      = $clog2(LIST_DEPTH);
  localparam int CNT_W       = $clog2(LIST_DEPTH + 1);
  localparam int SIZE_W      = 16;
  localparam int OFF_W       = 32;
  localparam int SUM_W       = ADDR_W + SIZE_W;
  localparam int POLICY_W    = 2;
  localparam int STATUS_W    = 2;
  localparam int COUNT_OUT_W = 7;
  localparam int SPACE_OUT_W = 22;
  localparam int COUNT_MAX   = 127;
  localparam int SPACE_MAX   = 4194303;

  localparam logic [STATUS_W-1:0] STATUS_HOLE = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_END  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd2;

  localparam logic [POLICY_W-1:0] POLICY_BEST  = 2'd1;
  localparam logic [POLICY_W-1:0] POLICY_WORST = 2'd2;

  localparam logic KIND_FREE = 1'b1;

  typedef struct packed {
    logic [SIZE_W-1:0] size;
    logic [OFF_W-1:0]  off;
  } entry_t;

  typedef struct packed {
    logic              found;
    logic [ADDR_W-1:0] idx;
    entry_t            ent;
  } pick_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FREE,
    S_SCAN,
    S_LAST,
    S_DECIDE,
    S_SHIFT,
    S_DRAIN,
    S_APPEND
  } state_e;

endpackage

// ===== hdl/hla_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// Depends on nothing.
module hla_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 48
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_o <= mem[rd_addr_i];
    end
  end

endmodule

// ===== hdl/hla_pick.sv =====
// Fit selector: watches entries streamed out of the hole RAM and keeps the chosen one.
// Depends on hla_pkg.
module hla_pick
  import hla_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                clear_i,
  input  logic                valid_i,
  input  logic [ADDR_W-1:0]   idx_i,
  input  entry_t              ent_i,
  input  logic [SIZE_W-1:0]   need_i,
  input  logic [POLICY_W-1:0] policy_i,
  output pick_t               pick_o
);

  pick_t pick_q, pick_d;
  logic  fits, better;

  always_comb begin
    fits   = ent_i.size >= need_i;
    // ties keep the earlier entry, so only strict improvement replaces
    better = !pick_q.found
          || (policy_i == POLICY_BEST  && ent_i.size < pick_q.ent.size)
          || (policy_i == POLICY_WORST && ent_i.size > pick_q.ent.size);
    pick_d = pick_q;
    if (clear_i) begin
      pick_d.found = 1'b0;
    end else if (valid_i && fits && better) begin
      pick_d.found = 1'b1;
      pick_d.idx   = idx_i;
      pick_d.ent   = ent_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pick_q <= '0;
    end else begin
      pick_q <= pick_d;
    end
  end

  assign pick_o = pick_q;

endmodule

// ===== hdl/hole_list_allocator_core.sv =====
// Hole list allocator: free list of (offset, size) holes in one RAM, first/best/worst fit.
// Allocate with H holes held: H RAM reads (none if empty), then, if hole p fits,
// the entries behind p move up one slot per cycle.
// The result strobe rises in the same cycle that busy drops and lasts one cycle.
// One item at a time; the next item may be taken during the strobe, which cannot stall.
// Reset clears the hole count, end pointer, free-space total and fit policy; RAM is not cleared.
module hole_list_allocator_core
  import hla_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start,
  output logic                   busy,
  input  logic                   kind_i,
  input  logic [SIZE_W-1:0]      size_i,
  input  logic [OFF_W-1:0]       offset_i,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [POLICY_W-1:0]    cfg_data_i,
  output logic                   done_o,
  output logic [STATUS_W-1:0]    status_o,
  output logic [OFF_W-1:0]       offset_res_o,
  output logic [COUNT_OUT_W-1:0] hole_count_o,
  output logic [SPACE_OUT_W-1:0] free_space_o
);

  state_e               state_q, state_d;
  logic [CNT_W-1:0]     held_q;
  logic [OFF_W-1:0]     end_q;
  logic [SUM_W-1:0]     space_q;
  logic [POLICY_W-1:0]  policy_q;
  logic [ADDR_W-1:0]    idx_q;
  logic                 rd_vld_q;
  logic [ADDR_W-1:0]    rd_idx_q;
  logic                 done_q, done_d;
  logic [SIZE_W-1:0]    size_q;
  logic [OFF_W-1:0]     off_q;
  logic [STATUS_W-1:0]  status_q;
  logic [OFF_W-1:0]     offres_q;

  logic                 accept;
  logic [ADDR_W-1:0]    last_idx;
  logic                 list_full;
  logic                 free_wr;
  logic [SIZE_W-1:0]    rem;
  logic                 rem_nz;

  logic                 wr_en, rd_en;
  logic [ADDR_W-1:0]    wr_addr, rd_addr;
  entry_t               wr_data, rd_data;

  logic                 pick_valid;
  pick_t                pick;

  assign busy        = state_q != S_IDLE;
  assign accept      = start && !busy;
  assign cfg_ready_o = 1'b1;
  assign last_idx    = ADDR_W'(held_q - CNT_W'(1));
  assign list_full   = held_q == CNT_W'(LIST_DEPTH);
  assign free_wr     = !list_full && size_q != '0;
  assign rem         = pick.ent.size - size_q;
  assign rem_nz      = pick.ent.size > size_q;
  assign pick_valid  = rd_vld_q && (state_q == S_SCAN || state_q == S_LAST);

  hla_ram #(
    .DEPTH(LIST_DEPTH),
    .WIDTH($bits(entry_t))
  ) u_ram (
    .clk_i    (clk_i),
    .wr_en_i  (wr_en),
    .wr_addr_i(wr_addr),
    .wr_data_i(wr_data),
    .rd_en_i  (rd_en),
    .rd_addr_i(rd_addr),
    .rd_data_o(rd_data)
  );

  hla_pick u_pick (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .clear_i (accept),
    .valid_i (pick_valid),
    .idx_i   (rd_idx_q),
    .ent_i   (rd_data),
    .need_i  (size_q),
    .policy_i(policy_q),
    .pick_o  (pick)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (kind_i == KIND_FREE) begin
            state_d = S_FREE;
          end else if (held_q == '0) begin
            state_d = S_DECIDE;
          end else begin
            state_d = S_SCAN;
          end
        end
      end
      S_FREE:   state_d = S_IDLE;
      S_SCAN:   state_d = (idx_q == last_idx) ? S_LAST : S_SCAN;
      S_LAST:   state_d = S_DECIDE;
      S_DECIDE: begin
        if (!pick.found) begin
          state_d = S_IDLE;
        end else if (pick.idx == last_idx) begin
          state_d = S_APPEND;
        end else begin
          state_d = S_SHIFT;
        end
      end
      S_SHIFT:  state_d = (idx_q == last_idx) ? S_DRAIN : S_SHIFT;
      S_DRAIN:  state_d = S_APPEND;
      S_APPEND: state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  // RAM port control and result strobe
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = idx_q;
    wr_en   = 1'b0;
    wr_addr = rd_idx_q - ADDR_W'(1);
    wr_data = rd_data;
    done_d  = 1'b0;
    unique case (state_q)
      S_FREE: begin
        wr_en        = free_wr;
        wr_addr      = ADDR_W'(held_q);
        wr_data.size = size_q;
        wr_data.off  = off_q;
        done_d       = 1'b1;
      end
      S_SCAN: rd_en = 1'b1;
      S_DECIDE: done_d = !pick.found;
      S_SHIFT: begin
        // read one slot ahead, write it back one slot lower
        rd_en = 1'b1;
        wr_en = rd_vld_q;
      end
      S_DRAIN: wr_en = rd_vld_q;
      S_APPEND: begin
        wr_en        = rem_nz;
        wr_addr      = last_idx;
        wr_data.size = rem;
        wr_data.off  = pick.ent.off + OFF_W'(size_q);
        done_d       = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      held_q   <= '0;
      end_q    <= '0;
      space_q  <= '0;
      policy_q <= '0;
      idx_q    <= '0;
      rd_vld_q <= 1'b0;
      rd_idx_q <= '0;
      done_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      done_q   <= done_d;
      rd_vld_q <= rd_en;
      if (rd_en) begin
        rd_idx_q <= rd_addr;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        policy_q <= cfg_data_i;
      end
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            idx_q <= '0;
          end
        end
        S_FREE: begin
          if (free_wr) begin
            held_q  <= held_q + CNT_W'(1);
            space_q <= space_q + SUM_W'(size_q);
          end
        end
        S_SCAN, S_SHIFT: idx_q <= idx_q + ADDR_W'(1);
        S_DECIDE: begin
          if (pick.found) begin
            idx_q   <= pick.idx + ADDR_W'(1);
            space_q <= space_q - SUM_W'(pick.ent.size);
          end else begin
            end_q <= end_q + OFF_W'(size_q);
          end
        end
        S_APPEND: begin
          // remainder reuses the slot freed at the tail; otherwise drop one hole
          if (rem_nz) begin
            space_q <= space_q + SUM_W'(rem);
          end else begin
            held_q <= held_q - CNT_W'(1);
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      size_q <= size_i;
      off_q  <= offset_i;
    end
    if (state_q == S_FREE) begin
      status_q <= list_full ? STATUS_FULL : STATUS_HOLE;
      offres_q <= '0;
    end else if (state_q == S_DECIDE && !pick.found) begin
      status_q <= STATUS_END;
      offres_q <= end_q;
    end else if (state_q == S_APPEND) begin
      status_q <= STATUS_HOLE;
      offres_q <= pick.ent.off;
    end
  end

  assign done_o       = done_q;
  assign status_o     = status_q;
  assign offset_res_o = offres_q;

  always_comb begin
    if (32'(held_q) > COUNT_MAX) begin
      hole_count_o = COUNT_OUT_W'(COUNT_MAX);
    end else begin
      hole_count_o = COUNT_OUT_W'(held_q);
    end
    if (32'(space_q) > SPACE_MAX) begin
      free_space_o = SPACE_OUT_W'(SPACE_MAX);
    end else begin
      free_space_o = SPACE_OUT_W'(space_q);
    end
  end

  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe held longer than one cycle");

  a_held_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_q <= CNT_W'(LIST_DEPTH))
    else $error("hole count beyond list depth");

  a_port_conflict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_en && rd_en) |-> wr_addr != rd_addr)
    else $error("RAM read and write hit the same entry");

  a_full_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o == STATUS_FULL) |-> list_full)
    else $error("list full reported with room left");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy)
    else $error("accepted item did not raise busy");

endmodule

// ===== sim/hla_checker.sv =====
// Checker for the hole list allocator: watches the item, result and policy write channels,
// keeps its own copy of the hole list and compares each result strobe with the oldest prediction.
// Depends on hla_pkg for widths, status codes and policy codes.
module hla_checker
  import hla_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic                   busy_i,
  input  logic                   kind_i,
  input  logic [SIZE_W-1:0]      size_i,
  input  logic [OFF_W-1:0]       offset_i,
  input  logic                   cfg_valid_i,
  input  logic                   cfg_ready_i,
  input  logic [POLICY_W-1:0]    cfg_data_i,
  input  logic                   done_i,
  input  logic [STATUS_W-1:0]    status_i,
  input  logic [OFF_W-1:0]       offset_res_i,
  input  logic [COUNT_OUT_W-1:0] hole_count_i,
  input  logic [SPACE_OUT_W-1:0] free_space_i,
  output int                     fails_o,
  output int                     open_o
);

  typedef struct packed {
    logic [STATUS_W-1:0]    status;
    logic [OFF_W-1:0]       off;
    logic [COUNT_OUT_W-1:0] count;
    logic [SPACE_OUT_W-1:0] space;
  } alloc_reply_t;

  alloc_reply_t        replies_due[$];
  alloc_reply_t        got;
  alloc_reply_t        want;
  int                  fail_cnt;

  logic [SIZE_W-1:0]   hole_sz [LIST_DEPTH];
  logic [OFF_W-1:0]    hole_off[LIST_DEPTH];
  int                  n_holes;
  logic [OFF_W-1:0]    end_ptr;
  longint unsigned     space_sum;
  logic [POLICY_W-1:0] fit_mode;

  task automatic add_hole(input logic [SIZE_W-1:0] sz, input logic [OFF_W-1:0] off);
    if (n_holes < LIST_DEPTH) begin
      hole_sz[n_holes]  = sz;
      hole_off[n_holes] = off;
      n_holes++;
      space_sum += sz;
    end
  endtask

  // Apply one accepted item to the hole list and queue the reply it must produce.
  task automatic serve_item(input logic kind, input logic [SIZE_W-1:0] sz,
                            input logic [OFF_W-1:0] off);
    alloc_reply_t      r;
    int                pick;
    int                i;
    bit                stop;
    logic [SIZE_W-1:0] hs;
    logic [OFF_W-1:0]  ho;
    r        = '0;
    r.status = STATUS_HOLE;
    if (kind == KIND_FREE) begin
      if (n_holes >= LIST_DEPTH) r.status = STATUS_FULL;
      else if (sz != 0) add_hole(sz, off);
    end else begin
      pick = n_holes;
      stop = 1'b0;
      for (i = 0; i < n_holes && !stop; i++) begin
        if (hole_sz[i] >= sz) begin
          if (pick == n_holes) begin
            pick = i;
            // first fit, and the spare code, take the first hole that fits
            if (fit_mode != POLICY_BEST && fit_mode != POLICY_WORST) stop = 1'b1;
          end else if (fit_mode == POLICY_BEST && hole_sz[i] < hole_sz[pick]) begin
            pick = i;
          end else if (fit_mode == POLICY_WORST && hole_sz[i] > hole_sz[pick]) begin
            pick = i;
          end
        end
      end
      if (pick < n_holes) begin
        hs = hole_sz[pick];
        ho = hole_off[pick];
        for (i = pick; i + 1 < n_holes; i++) begin
          hole_sz[i]  = hole_sz[i+1];
          hole_off[i] = hole_off[i+1];
        end
        n_holes--;
        space_sum -= hs;
        if (hs > sz) add_hole(hs - sz, ho + OFF_W'(sz));
        r.off = ho;
      end else begin
        r.off    = end_ptr;
        end_ptr  = end_ptr + OFF_W'(sz);
        r.status = STATUS_END;
      end
    end
    r.count = (n_holes > COUNT_MAX) ? COUNT_OUT_W'(COUNT_MAX) : COUNT_OUT_W'(n_holes);
    r.space = (space_sum > SPACE_MAX) ? SPACE_OUT_W'(SPACE_MAX) : SPACE_OUT_W'(space_sum);
    replies_due.push_back(r);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      replies_due.delete();
      n_holes   = 0;
      end_ptr   = '0;
      space_sum = 0;
      fit_mode  = '0;
      fail_cnt  = 0;
      fails_o  <= 0;
      open_o   <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) fit_mode = cfg_data_i;
      if (start_i && !busy_i) serve_item(kind_i, size_i, offset_i);
      if (done_i) begin
        got = '{status_i, offset_res_i, hole_count_i, free_space_i};
        if (replies_due.size() == 0) begin
          $error("result with nothing outstanding: status %0d offset %0h", status_i,
                 offset_res_i);
          fail_cnt++;
        end else begin
          want = replies_due.pop_front();
          if (got.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            fail_cnt++;
          end
          if (got.off !== want.off) begin
            $error("offset_res: expected %0h, got %0h", want.off, got.off);
            fail_cnt++;
          end
          if (got.count !== want.count) begin
            $error("hole_count: expected %0d, got %0d", want.count, got.count);
            fail_cnt++;
          end
          if (got.space !== want.space) begin
            $error("free_space: expected %0d, got %0d", want.space, got.space);
            fail_cnt++;
          end
        end
      end
      fails_o <= fail_cnt;
      open_o  <= replies_due.size();
    end
  end

endmodule

// ===== sim/hole_list_allocator_core_tb.sv =====
// Testbench top for hole_list_allocator_core: clock, reset, item and policy stimulus, verdict.
// Instantiates the block and hla_checker, which predicts and compares results.
// Depends on hla_pkg.
module hole_list_allocator_core_tb;
  import hla_pkg::*;

  localparam logic                KIND_ALLOC   = ~KIND_FREE;
  localparam logic [POLICY_W-1:0] POLICY_FIRST = 2'd0;
  localparam logic [POLICY_W-1:0] POLICY_SPARE = 2'd3;
  localparam int                  DRAIN_CYCLES = 2 * LIST_DEPTH + 16;
  localparam int                  PHASES       = 12;
  localparam int                  PHASE_ITEMS  = 108;

  logic                   clk_i = 1'b0;
  logic                   rst_ni;
  logic                   start;
  logic                   busy;
  logic                   kind_i;
  logic [SIZE_W-1:0]      size_i;
  logic [OFF_W-1:0]       offset_i;
  logic                   cfg_valid_i;
  logic                   cfg_ready_o;
  logic [POLICY_W-1:0]    cfg_data_i;
  logic                   done_o;
  logic [STATUS_W-1:0]    status_o;
  logic [OFF_W-1:0]       offset_res_o;
  logic [COUNT_OUT_W-1:0] hole_count_o;
  logic [SPACE_OUT_W-1:0] free_space_o;

  int                     fails;
  int                     open_items;
  int                     gap_cap;
  logic [POLICY_W-1:0]    plan[8];

  always #10 clk_i = ~clk_i;

  hole_list_allocator_core u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .kind_i       (kind_i),
    .size_i       (size_i),
    .offset_i     (offset_i),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .done_o       (done_o),
    .status_o     (status_o),
    .offset_res_o (offset_res_o),
    .hole_count_o (hole_count_o),
    .free_space_o (free_space_o)
  );

  hla_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start),
    .busy_i       (busy),
    .kind_i       (kind_i),
    .size_i       (size_i),
    .offset_i     (offset_i),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_i  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .done_i       (done_o),
    .status_i     (status_o),
    .offset_res_i (offset_res_o),
    .hole_count_i (hole_count_o),
    .free_space_i (free_space_o),
    .fails_o      (fails),
    .open_o       (open_items)
  );

  // Present one item and hold it until accepted; start stays high for a back-to-back item.
  task automatic issue(input logic kind, input logic [SIZE_W-1:0] sz,
                       input logic [OFF_W-1:0] off);
    int gap;
    gap = $urandom_range(0, gap_cap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start    <= 1'b1;
    kind_i   <= kind;
    size_i   <= sz;
    offset_i <= off;
    do @(posedge clk_i); while (busy);
  endtask

  // Drop start and wait until every result is back and the block is idle.
  task automatic quiesce();
    start <= 1'b0;
    do @(negedge clk_i); while (open_items != 0 || busy);
    @(posedge clk_i);
  endtask

  task automatic set_policy(input logic [POLICY_W-1:0] mode);
    quiesce();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= mode;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [SIZE_W-1:0] pick_size(input int small_max);
    int c;
    c = $urandom_range(0, 9);
    case (c)
      0: begin
        case ($urandom_range(0, 2))
          0:       pick_size = '0;
          1:       pick_size = SIZE_W'(1);
          default: pick_size = '1;
        endcase
      end
      1, 2:    pick_size = SIZE_W'($urandom_range(0, 65535));
      default: pick_size = SIZE_W'($urandom_range(1, small_max));
    endcase
  endfunction

  // Bursts of frees (some long enough to fill the list) and allocates, with some noise.
  task automatic random_phase(input int n_items);
    int left;
    int burst;
    int mode;
    int i;
    left = n_items;
    while (left > 0) begin
      mode    = $urandom_range(0, 9);
      burst   = (mode == 0) ? $urandom_range(LIST_DEPTH + 2, LIST_DEPTH + 8)
                            : $urandom_range(1, 40);
      gap_cap = ($urandom_range(0, 3) == 0) ? 0 : 4;
      for (i = 0; i < burst && left > 0; i++) begin
        if (mode < 4)
          issue(KIND_FREE, pick_size(256), $urandom());
        else if (mode < 8)
          issue(KIND_ALLOC, pick_size(120), $urandom());
        else
          issue(logic'($urandom_range(0, 1)), pick_size(200), $urandom());
        left--;
      end
    end
  endtask

  initial begin
    int p;
    start       <= 1'b0;
    kind_i      <= KIND_ALLOC;
    size_i      <= '0;
    offset_i    <= '0;
    cfg_valid_i <= 1'b0;
    cfg_data_i  <= POLICY_FIRST;
    rst_ni      <= 1'b0;
    gap_cap      = 4;
    plan = '{POLICY_SPARE, POLICY_BEST, POLICY_WORST, POLICY_FIRST,
             POLICY_WORST, POLICY_SPARE, POLICY_BEST, POLICY_FIRST};
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // policy from reset: zero-size allocate with an empty list, end allocations, extremes
    issue(KIND_ALLOC, '0, 32'h0);
    issue(KIND_ALLOC, SIZE_W'(1), 32'hFFFF_FFFF);
    issue(KIND_ALLOC, '1, 32'h0);
    issue(KIND_FREE, '0, 32'd123);
    issue(KIND_FREE, '1, 32'hFFFF_FFFF);
    issue(KIND_FREE, SIZE_W'(10), 32'h0);
    issue(KIND_FREE, SIZE_W'(10), 32'h100);
    issue(KIND_FREE, '1, 32'h200);
    issue(KIND_ALLOC, '0, 32'h0);
    issue(KIND_ALLOC, SIZE_W'(20), 32'h0);

    // best fit: equal sizes go to the earliest entry; remainder offset wraps
    set_policy(POLICY_BEST);
    issue(KIND_ALLOC, SIZE_W'(10), 32'h0);
    issue(KIND_ALLOC, SIZE_W'(5), 32'h0);
    issue(KIND_FREE, SIZE_W'(32), 32'hFFFF_FFF0);
    issue(KIND_ALLOC, SIZE_W'(20), 32'h0);
    issue(KIND_ALLOC, '1, 32'h0);

    set_policy(POLICY_WORST);
    issue(KIND_ALLOC, SIZE_W'(1), 32'h0);
    issue(KIND_ALLOC, '1, 32'h0);
    issue(KIND_ALLOC, '0, 32'h0);
    issue(KIND_FREE, SIZE_W'(7), 32'h7);

    set_policy(POLICY_SPARE);
    issue(KIND_ALLOC, SIZE_W'(3), 32'h0);
    issue(KIND_ALLOC, '1, 32'h0);

    for (p = 0; p < PHASES; p++) begin
      set_policy(p < 8 ? plan[p] : POLICY_W'($urandom_range(0, 3)));
      random_phase(PHASE_ITEMS);
    end

    quiesce();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (open_items != 0) $error("%0d results never arrived", open_items);
    if (fails == 0 && open_items == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
